FILE: hw/rtl/cbc_pkg.sv
package cbc_pkg;

    // Kind of bus access carried by one result beat.
    typedef enum logic [2:0] {
        REGION_FIXED_ROM  = 3'd0,
        REGION_BANKED_ROM = 3'd1,
        REGION_EXT_RAM    = 3'd2,
        REGION_CONTROL    = 3'd3,
        REGION_OTHER      = 3'd4
    } region_t;

    // Controller types. The remaining code of the two-bit register acts as no controller.
    typedef enum logic [1:0] {
        CTRL_NONE = 2'd0,
        CTRL_MBC1 = 2'd1,
        CTRL_MBC5 = 2'd2
    } ctrl_type_t;

    // Configuration register indexes, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_CONTROLLER_TYPE    = 2'd0,
        REG_ROM_BANK_COUNT_LOG = 2'd1,
        REG_RAM_BANK_COUNT     = 2'd2
    } reg_index_t;

    localparam int ADDR_W       = 16;
    localparam int DATA_W       = 8;
    localparam int ROM_BANK_W   = 16;
    localparam int RAM_BANK_W   = 4;
    localparam int ROM_ADDR_W   = 30;
    localparam int RAM_ADDR_W   = 17;
    localparam int ROM_OFFS_W   = 14;
    localparam int RAM_OFFS_W   = 13;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 72;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    localparam logic [ADDR_W-1:0] ADDR_ROM_BANK  = 16'h2000;
    localparam logic [ADDR_W-1:0] ADDR_ROM_HIGH  = 16'h3000;
    localparam logic [ADDR_W-1:0] ADDR_BANKED    = 16'h4000;
    localparam logic [ADDR_W-1:0] ADDR_MODE      = 16'h6000;
    localparam logic [ADDR_W-1:0] ADDR_VRAM      = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_EXT_RAM   = 16'hA000;
    localparam logic [ADDR_W-1:0] ADDR_WRAM      = 16'hC000;

    localparam logic [3:0]            RAM_ENABLE_KEY = 4'hA;
    localparam logic [4:0]            MBC1_BANK_MASK = 5'h1F;
    localparam logic [ROM_BANK_W-1:0] ROM_HIGH_MASK  = 16'hFF00;
    localparam logic [ROM_BANK_W-1:0] ROM_LOW_MASK   = 16'h00FF;
    localparam logic [4:0]            RAM_COUNT_MAX  = 5'd16;

endpackage

FILE: hw/rtl/cartridge_bank_controller.sv
// A result beat appears on the master side in the cycle after its access beat is taken.
// One access beat is taken per cycle while the result stream accepts; the decode and the
// bank register update are done combinationally before the result register.
// The slave side stalls only while a result beat waits in the output register unaccepted.
// Reset (rst_n low, asynchronous): ROM bank 1, RAM bank 0, RAM disabled, all configuration
// registers 0, no result beat pending.
module cartridge_bank_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cbc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cbc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cbc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    // Access stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [cbc_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // address[15:0], write_data[23:16]
    input  logic                           s_axis_tuser,  // func (0 read, 1 write)
    // Result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [cbc_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // rom_address[29:0],
                                                          // ram_address[46:30],
                                                          // ram_enabled[47],
                                                          // rom_bank_now[63:48],
                                                          // ram_bank_now[67:64], zeros above
    output logic [2:0]                     m_axis_tuser   // region
);
    import cbc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0] ctrl_type_reg;
    logic [3:0] rom_count_log_reg;
    logic [4:0] ram_count_reg;
    logic       cfg_write;
    reg_index_t cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_type_reg     <= 2'd0;
            rom_count_log_reg <= 4'd0;
            ram_count_reg     <= 5'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CONTROLLER_TYPE:    ctrl_type_reg     <= pwdata[1:0];
                REG_ROM_BANK_COUNT_LOG: rom_count_log_reg <= pwdata[3:0];
                REG_RAM_BANK_COUNT:     ram_count_reg     <= pwdata[4:0];
                default:                ;
            endcase
        end
    end

    // Reads return the register zero-extended; unused addresses read as zero.
    always_comb
    begin
        unique case (cfg_index)
            REG_CONTROLLER_TYPE:    prdata = {30'd0, ctrl_type_reg};
            REG_ROM_BANK_COUNT_LOG: prdata = {28'd0, rom_count_log_reg};
            REG_RAM_BANK_COUNT:     prdata = {27'd0, ram_count_reg};
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Bank state and access decode
    // ------------------------------------------------------------------
    logic [ROM_BANK_W-1:0] rom_bank_reg, rom_bank_next;
    logic [RAM_BANK_W-1:0] ram_bank_reg, ram_bank_next;
    logic                  ram_enable_reg, ram_enable_next;

    logic                  in_accept;
    logic                  is_write;
    logic [ADDR_W-1:0]     addr;
    logic [DATA_W-1:0]     data;
    logic                  ctrl_active;
    logic [16:0]           rom_count;
    logic [ROM_BANK_W-1:0] rom_mask;
    logic [4:0]            mbc1_bank;
    logic [4:0]            ram_limit;
    logic [ROM_BANK_W-1:0] mbc5_low_sum;
    logic [ROM_BANK_W-1:0] read_bank;

    region_t               region_next;
    logic [ROM_ADDR_W-1:0] rom_addr_next;
    logic [RAM_ADDR_W-1:0] ram_addr_next;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign is_write  = s_axis_tuser;
    assign addr      = s_axis_tdata[ADDR_W-1:0];
    assign data      = s_axis_tdata[ADDR_W +: DATA_W];

    assign ctrl_active = (ctrl_type_reg == CTRL_MBC1) || (ctrl_type_reg == CTRL_MBC5);

    // The ROM holds 2 << log banks; the mask is that count minus one, kept to 16 bits.
    assign rom_count = 17'd2 << rom_count_log_reg;
    assign rom_mask  = ROM_BANK_W'(rom_count - 17'd1);

    // MBC1 bank: five bits, zero maps to one, then wrapped when the ROM has fewer
    // than 32 banks.
    always_comb
    begin
        mbc1_bank = data[4:0] & MBC1_BANK_MASK;
        if (mbc1_bank == 5'd0)
        begin
            mbc1_bank = 5'd1;
        end
        if (rom_count_log_reg < 4'd4)
        begin
            mbc1_bank = mbc1_bank & rom_mask[4:0];
        end
    end

    assign ram_limit    = (ram_count_reg > RAM_COUNT_MAX) ? RAM_COUNT_MAX : ram_count_reg;
    assign mbc5_low_sum = ((rom_bank_reg & ROM_HIGH_MASK) + {8'd0, data}) & rom_mask;

    // Register updates caused by a control write.
    always_comb
    begin
        rom_bank_next   = rom_bank_reg;
        ram_bank_next   = ram_bank_reg;
        ram_enable_next = ram_enable_reg;
        if (in_accept && is_write && (addr < ADDR_VRAM) && ctrl_active)
        begin
            if (addr < ADDR_ROM_BANK)
            begin
                ram_enable_next = (data[3:0] == RAM_ENABLE_KEY);
            end
            else if (ctrl_type_reg == CTRL_MBC1)
            begin
                if (addr < ADDR_BANKED)
                begin
                    rom_bank_next = {11'd0, mbc1_bank};
                end
                else if (addr < ADDR_MODE)
                begin
                    if (ram_count_reg > 5'd1)
                    begin
                        ram_bank_next = ({3'd0, ram_limit} > data) ? data[3:0] : 4'd0;
                    end
                end
            end
            else
            begin
                if (addr < ADDR_ROM_HIGH)
                begin
                    rom_bank_next = mbc5_low_sum;
                end
                else if (addr < ADDR_BANKED)
                begin
                    rom_bank_next = {data, rom_bank_reg[7:0] & ROM_LOW_MASK[7:0]};
                end
                else if (addr < ADDR_MODE)
                begin
                    ram_bank_next = data[3:0];
                end
            end
        end
    end

    // Without an active controller the banked window always shows bank 1.
    assign read_bank = ctrl_active ? rom_bank_reg : 16'd1;

    always_comb
    begin
        region_next   = REGION_OTHER;
        rom_addr_next = '0;
        ram_addr_next = '0;
        if (addr < ADDR_VRAM)
        begin
            if (is_write)
            begin
                region_next = REGION_CONTROL;
            end
            else if (addr < ADDR_BANKED)
            begin
                region_next   = REGION_FIXED_ROM;
                rom_addr_next = {14'd0, addr};
            end
            else
            begin
                region_next   = REGION_BANKED_ROM;
                rom_addr_next = {read_bank, addr[ROM_OFFS_W-1:0]};
            end
        end
        else if ((addr >= ADDR_EXT_RAM) && (addr < ADDR_WRAM))
        begin
            region_next   = REGION_EXT_RAM;
            ram_addr_next = {ram_bank_reg, addr[RAM_OFFS_W-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg   <= 16'd1;
            ram_bank_reg   <= 4'd0;
            ram_enable_reg <= 1'b0;
        end
        else
        begin
            rom_bank_reg   <= rom_bank_next;
            ram_bank_reg   <= ram_bank_next;
            ram_enable_reg <= ram_enable_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register. A new access is taken whenever the register is empty or
    // its beat leaves in the same cycle, so accesses stream at one per cycle unless stalled.
    // ------------------------------------------------------------------
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    region_t              out_region_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    // The bank fields report the state after this access, so they take the next values.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_region_reg <= region_next;
            out_data_reg   <= {4'd0, ram_bank_next, rom_bank_next, ram_enable_next,
                               ram_addr_next, rom_addr_next};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_region_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> m_axis_tvalid)
        else $error("accepted access produced no result beat");

    a_no_ctrl_keeps_banks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !ctrl_active) |=> ($stable(rom_bank_reg) && $stable(ram_bank_reg)
                                         && $stable(ram_enable_reg)))
        else $error("bank state changed without an active controller");

    a_ram_enable_key: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && is_write && ctrl_active && (addr < ADDR_ROM_BANK))
        |=> (ram_enable_reg == ($past(data[3:0]) == RAM_ENABLE_KEY)))
        else $error("RAM enable flag does not follow the enable write");

endmodule
